// ===== rtl/core/fpcvt_pkg.sv =====
// Package for the half/single converter: opcodes, widths, field constants.
// No dependencies.
`default_nettype none
package fpcvt_pkg;
	localparam int DataW = 32;
	localparam logic OP_H2S = 1'b0;
	localparam logic OP_S2H = 1'b1;
	localparam logic [31:0] S_NAN = 32'h7fffffff;
	localparam logic [15:0] H_NAN = 16'h7fff;
	localparam logic [15:0] H_INF = 16'h7c00;

	typedef struct packed {
		logic        opcode;
		logic [31:0] data;
		logic        last;
	} item_t;

	typedef struct packed {
		logic [31:0] data;
		logic        last;
	} res_t;
endpackage
`default_nettype wire

// ===== rtl/core/fpcvt_if.sv =====
// Valid/ready channel interfaces for the converter's input and result items.
// Depends on nothing; the payload fields are declared directly.
`default_nettype none
interface fpcvt_in_if;
	logic                valid;
	logic                ready;
	logic                opcode;
	logic [31:0]         data_in;
	logic                last_in;
	modport source (output valid, opcode, data_in, last_in, input ready);
	modport sink   (input valid, opcode, data_in, last_in, output ready);
endinterface

interface fpcvt_out_if;
	logic                valid;
	logic                ready;
	logic [31:0]         data_out;
	logic                last_out;
	modport source (output valid, data_out, last_out, input ready);
	modport sink   (input valid, data_out, last_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/fp16_fp32_converter.sv =====
// Top level of the half/single converter: a three-stage pipeline.
// Depends on fpcvt_pkg and the channel interfaces in fpcvt_if.sv.
//
//   channel  dir  payload
//   in       sink opcode, data_in[31:0], last_in
//   out      src  data_out[31:0], last_out
//
// Each item passes the three register stages from acceptance to result; one
// item per cycle while out.ready keeps the pipeline moving. The stages are
// decode/shift amount, shift and round bits, round add and packing.
// arst_n clears the stage valid bits only. A stage advances when the stage
// after it is free or moving; a stall holds occupied stages back to a bubble.
`default_nettype none
module fp16_fp32_converter (
	input  wire clk,
	input  wire arst_n,
	fpcvt_in_if.sink    in,
	fpcvt_out_if.source out
);
	// stage handshakes
	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;
	assign adv3 = !v_s3 || out.ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in.ready = adv1;

	// stage 1: decode
	logic        op_s1, last_s1, sign_s1;
	logic [7:0]  ex_s1;
	logic [22:0] man_s1;
	logic [4:0]  hex_s1;
	logic [9:0]  hman_s1;
	logic [3:0]  lz_s1;

	logic [3:0] lz_c;
	always_comb begin
		lz_c = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (in.data_in[i]) lz_c = 4'(9 - i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv1) v_s1 <= in.valid;
	end
	always_ff @(posedge clk) begin
		if (adv1 && in.valid) begin
			op_s1   <= in.opcode;
			last_s1 <= in.last_in;
			sign_s1 <= (in.opcode == fpcvt_pkg::OP_H2S) ? in.data_in[15] : in.data_in[31];
			ex_s1   <= in.data_in[30:23];
			man_s1  <= in.data_in[22:0];
			hex_s1  <= in.data_in[14:10];
			hman_s1 <= in.data_in[9:0];
			lz_s1   <= lz_c;
		end
	end

	// stage 2: shift; half->single finished here, single->half gets round bits
	logic        op_s2, last_s2, sign_s2;
	logic [31:0] wide_s2;
	logic [15:0] u_s2;
	logic        rnd_s2, stk_s2, fin_s2;

	logic [31:0] wide_c;
	logic [15:0] u_c;
	logic        rnd_c, stk_c, fin_c;
	logic [9:0]  hn_c;
	logic [7:0]  he_c;
	logic [23:0] m24;
	logic [23:0] msh;
	logic [4:0]  sh;
	logic [47:0] cat;
	always_comb begin
		// half to single
		hn_c = 10'(hman_s1 << (lz_s1 + 4'd1));
		he_c = 8'd113 - 8'(lz_s1) - 8'd1;
		if (hex_s1 == 5'd31)
			wide_c = (hman_s1 != 10'd0) ? fpcvt_pkg::S_NAN : {sign_s1, 8'hff, 23'd0};
		else if (hex_s1 != 5'd0)
			wide_c = {sign_s1, 8'(hex_s1) + 8'd112, hman_s1, 13'd0};
		else if (hman_s1 == 10'd0)
			wide_c = {sign_s1, 31'd0};
		else
			wide_c = {sign_s1, he_c, hn_c, 13'd0};
		// single to half
		m24 = {1'b1, man_s1};
		sh = 5'd0; cat = 48'd0; msh = 24'd0;
		u_c = 16'd0; rnd_c = 1'b0; stk_c = 1'b0; fin_c = 1'b0;
		if (ex_s1 == 8'd0 && man_s1 == 23'd0) begin
			fin_c = 1'b1;
		end else if (ex_s1 > 8'd142) begin
			fin_c = 1'b1;
			u_c = (ex_s1 == 8'hff && man_s1 != 23'd0) ? fpcvt_pkg::H_NAN : fpcvt_pkg::H_INF;
		end else if (ex_s1 >= 8'd113) begin
			u_c = {1'b0, 5'(ex_s1 - 8'd112), man_s1[22:13]};
			rnd_c = man_s1[12];
			stk_c = man_s1[11:0] != 12'd0;
		end else if (ex_s1 >= 8'd82) begin
			// rs = 113 - ex, 1..31
			sh = 5'(8'd113 - ex_s1);
			cat = {m24, 24'd0} >> sh;
			msh = cat[47:24];
			u_c = {6'd0, msh[22:13]};
			rnd_c = msh[12];
			stk_c = (msh[11:0] != 12'd0) || (cat[23:0] != 24'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv2) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			op_s2   <= op_s1;
			last_s2 <= last_s1;
			sign_s2 <= sign_s1;
			wide_s2 <= wide_c;
			u_s2    <= u_c;
			rnd_s2  <= rnd_c;
			stk_s2  <= stk_c;
			fin_s2  <= fin_c;
		end
	end

	// stage 3: round to nearest even and pack
	logic [31:0] data_s3;
	logic        last_s3;
	logic [15:0] ur_c;
	always_comb begin
		ur_c = u_s2;
		if (!fin_s2 && rnd_s2 && (stk_s2 || u_s2[0])) ur_c = u_s2 + 16'd1;
		if (!(fin_s2 && u_s2 == fpcvt_pkg::H_NAN)) ur_c = ur_c | {sign_s2, 15'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv3) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			last_s3 <= last_s2;
			data_s3 <= (op_s2 == fpcvt_pkg::OP_S2H) ? {16'd0, ur_c} : wide_s2;
		end
	end

	assign out.valid    = v_s3;
	assign out.data_out = data_s3;
	assign out.last_out = last_s3;

	// a held result stays put while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.ready |=> out.valid && $stable(out.data_out))
		else $error("result changed under stall");
	// an accepted item shows as a valid stage 1 in the cycle after acceptance
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in.valid && in.ready |=> v_s1)
		else $error("accepted item lost");
	// a narrowed result keeps its upper half zero
	a_upper: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && adv3 && op_s2 == fpcvt_pkg::OP_S2H |=> out.data_out[31:16] == 16'd0)
		else $error("half result upper bits set");
endmodule
`default_nettype wire

// ===== sim/fp16_fp32_converter_tb.sv =====
// Testbench for fp16_fp32_converter: drives half/single conversions through
// the valid/ready channels and checks every result against an in-bench model.
// Depends on fpcvt_pkg and the channel interfaces in fpcvt_if.sv.
`timescale 1ns / 1ps
module fp16_fp32_converter_tb;

	localparam int MaxCycles = 400000;
	localparam int DrainCycles = 8;

	logic clk;
	logic arst_n;

	fpcvt_in_if  in_ch();
	fpcvt_out_if out_ch();

	fp16_fp32_converter i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_ch.sink),
		.out(out_ch.source)
	);

	fpcvt_pkg::item_t pending_items[$];
	fpcvt_pkg::res_t  expected_results[$];
	int    fail_count;
	int    checked_count;
	int    h2s_count;
	int    s2h_count;
	int    cycle_count;
	bit    stim_done;
	bit    hold_sender;
	bit    hold_receiver;
	bit    in_accepted;
	int    send_gap;
	int    recv_gap;
	int    hold_count;

	// Widen a half pattern to single.
	function automatic logic [31:0] widen_half(input logic [15:0] h);
		logic        sgn;
		logic [4:0]  ex;
		logic [9:0]  man;
		logic [10:0] norm;
		logic [7:0]  e;
		sgn = h[15];
		ex = h[14:10];
		man = h[9:0];
		if (ex != 5'd0 && ex != 5'd31) begin
			return {sgn, 8'(ex) + 8'd112, man, 13'd0};
		end
		if (ex == 5'd0) begin
			if (man == 10'd0)
				return {sgn, 31'd0};
			norm = {1'b0, man};
			e = 8'd113;
			while (norm[10] == 1'b0) begin
				norm = norm << 1;
				e = e - 8'd1;
			end
			return {sgn, e, norm[9:0], 13'd0};
		end
		if (man != 10'd0)
			return fpcvt_pkg::S_NAN;
		return {sgn, 8'hff, 23'd0};
	endfunction

	// Narrow a single pattern to half, round to nearest even.
	function automatic logic [31:0] narrow_single(input logic [31:0] s);
		logic [15:0] sgn;
		int          e;
		int          rs;
		logic [31:0] man;
		logic [31:0] u;
		logic        sticky;
		logic        rnd;
		sgn = {s[31], 15'd0};
		e = int'(s[30:23]) - 127;
		man = {9'd0, s[22:0]};
		sticky = 1'b0;
		if (s[30:0] == 31'd0)
			return {16'd0, sgn};
		if (e > 15) begin
			if (e == 128 && man != 0)
				return {16'd0, fpcvt_pkg::H_NAN};
			return {16'd0, sgn | fpcvt_pkg::H_INF};
		end
		if (e >= -14) begin
			u = ((e + 15) & 32'h1f) << 10;
			u = u | (man >> 13);
		end else begin
			rs = -14 - e;
			if (rs < 32) begin
				man = man | (32'd1 << 23);
				sticky = (man & ((32'd1 << rs) - 32'd1)) != 0;
				man = man >> rs;
				u = (man >> 13) & 32'h3ff;
			end else begin
				man = 0;
				u = 0;
			end
		end
		rnd = man[12];
		sticky = sticky | (man[11:0] != 12'd0);
		if (rnd && (sticky || u[0]))
			u = (u + 32'd1) & 32'hffff;
		return {16'd0, u[15:0] | sgn};
	endfunction

	function automatic fpcvt_pkg::res_t convert_item(input fpcvt_pkg::item_t it);
		fpcvt_pkg::res_t r;
		r.data = (it.opcode == fpcvt_pkg::OP_H2S) ? widen_half(it.data[15:0])
			: narrow_single(it.data);
		r.last = it.last;
		return r;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 40)
			return 0;
		if ($urandom_range(0, 99) < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic fpcvt_pkg::item_t make_item(input logic op, input logic [31:0] d);
		fpcvt_pkg::item_t it;
		it.opcode = op;
		it.data = d;
		it.last = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// Random single with exponent mostly near the half range.
	function automatic logic [31:0] rand_single();
		logic [7:0] ex;
		int         k;
		k = $urandom_range(0, 9);
		if (k < 6)
			ex = 8'($urandom_range(127 - 26, 127 + 16));
		else if (k < 7)
			ex = 8'($urandom_range(0, 1)) * 8'hff;
		else
			ex = 8'($urandom_range(0, 255));
		return {1'($urandom_range(0, 1)), ex, 23'($urandom)};
	endfunction

	function automatic logic [31:0] rand_half();
		logic [4:0] ex;
		int         k;
		k = $urandom_range(0, 9);
		if (k < 2)
			ex = 5'd0;
		else if (k < 3)
			ex = 5'd31;
		else
			ex = 5'($urandom_range(0, 31));
		return {16'($urandom), 1'($urandom_range(0, 1)), ex, 10'($urandom)};
	endfunction

	// Toggle the clock every half period.
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Fill the item queue: directed corners, then random items.
	initial begin
		logic [31:0] directed_h[$];
		logic [31:0] directed_s[$];
		directed_h = '{32'h0000_0000, 32'h0000_8000, 32'hffff_0001, 32'h0000_83ff,
			32'h0000_7c00, 32'h0000_fc00, 32'h0000_7e01, 32'h0000_fc01,
			32'h0000_3c00, 32'h0000_7bff, 32'h0000_0400};
		directed_s = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h7f80_0000,
			32'hff80_0000, 32'hffc0_0001, 32'h4780_0000, 32'h477f_f000,
			32'h3f80_1000, 32'h3f80_3000, 32'h3880_0000, 32'h3380_0000,
			32'h3300_0000, 32'hb3c0_0000};
		arst_n = 1'b0;
		stim_done = 1'b0;
		hold_sender = 1'b0;
		foreach (directed_h[i])
			pending_items.push_back(make_item(fpcvt_pkg::OP_H2S, directed_h[i]));
		foreach (directed_s[i])
			pending_items.push_back(make_item(fpcvt_pkg::OP_S2H, directed_s[i]));
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int i = 0; i < 650; i++) begin
			if ($urandom_range(0, 1))
				pending_items.push_back(make_item(fpcvt_pkg::OP_S2H, rand_single()));
			else
				pending_items.push_back(make_item(fpcvt_pkg::OP_H2S, rand_half()));
			// pause the sender once until the block is empty
			if (i == 300) begin
				wait (pending_items.size() == 0);
				hold_sender = 1'b1;
				wait (expected_results.size() == 0);
				@(negedge clk);
				hold_sender = 1'b0;
			end
		end
		wait (pending_items.size() == 0);
		stim_done = 1'b1;
	end

	// Drive items on the falling edge.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.opcode <= fpcvt_pkg::OP_H2S;
			in_ch.data_in <= '0;
			in_ch.last_in <= 1'b0;
			send_gap <= 0;
		end else if (in_ch.valid && !in_accepted) begin
			// hold the offered item until a rising edge takes it
		end else if (send_gap > 0) begin
			in_ch.valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (pending_items.size() != 0 && !hold_sender) begin
			in_ch.valid <= 1'b1;
			in_ch.opcode <= pending_items[0].opcode;
			in_ch.data_in <= pending_items[0].data;
			in_ch.last_in <= pending_items[0].last;
			expected_results.push_back(convert_item(pending_items[0]));
			if (pending_items[0].opcode == fpcvt_pkg::OP_H2S)
				h2s_count <= h2s_count + 1;
			else
				s2h_count <= s2h_count + 1;
			void'(pending_items.pop_front());
			send_gap <= pick_gap();
		end else begin
			in_ch.valid <= 1'b0;
		end
	end

	// Receiver stalls at random, plus one long hold-off.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_gap <= 0;
			hold_count <= 0;
			hold_receiver <= 1'b0;
		end else if (cycle_count == 400 && !hold_receiver) begin
			hold_receiver <= 1'b1;
			hold_count <= 60;
			out_ch.ready <= 1'b0;
		end else if (hold_receiver) begin
			hold_count <= hold_count - 1;
			if (hold_count == 1) begin
				hold_receiver <= 1'b0;
				out_ch.ready <= 1'b1;
			end
		end else if (recv_gap > 0) begin
			out_ch.ready <= 1'b0;
			recv_gap <= recv_gap - 1;
		end else begin
			out_ch.ready <= 1'b1;
			recv_gap <= pick_gap();
		end
	end

	// Check results, note input acceptance and count cycles on the rising edge.
	always @(posedge clk) begin
		fpcvt_pkg::res_t exp_r;
		cycle_count <= cycle_count + 1;
		in_accepted <= arst_n && in_ch.valid && in_ch.ready;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: data_out %h", out_ch.data_out);
				fail_count <= fail_count + 1;
			end else begin
				exp_r = expected_results.pop_front();
				checked_count <= checked_count + 1;
				if (out_ch.data_out !== exp_r.data) begin
					$error("data_out: expected %h, got %h", exp_r.data, out_ch.data_out);
					fail_count <= fail_count + 1;
				end
				if (out_ch.last_out !== exp_r.last) begin
					$error("last_out: expected %b, got %b", exp_r.last, out_ch.last_out);
					fail_count <= fail_count + 1;
				end
			end
		end
	end

	initial begin
		fail_count = 0;
		checked_count = 0;
		h2s_count = 0;
		s2h_count = 0;
		cycle_count = 0;
	end

	// Finish after drain, or on timeout.
	initial begin
		fork
			begin
				wait (stim_done && !in_ch.valid && expected_results.size() == 0);
				repeat (DrainCycles) @(posedge clk);
			end
			begin
				wait (cycle_count >= MaxCycles);
				$display("timeout after %0d cycles", cycle_count);
				$display("CHECK FAILED");
				$finish;
			end
		join_any
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			fail_count = fail_count + 1;
		end
		$display("checked %0d results: %0d half-to-single, %0d single-to-half, %0d cycles",
			checked_count, h2s_count, s2h_count, cycle_count);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/core/fpcvt_pkg.sv
rtl/core/fpcvt_if.sv
rtl/core/fp16_fp32_converter.sv
sim/fp16_fp32_converter_tb.sv
